@@ hw/rtl/mwgc_pkg.sv @@
// Package with the shared types, sizes and codes of the median window gain calibrator.
package mwgc_pkg;

    // Window depth and the widths that follow from it.
    localparam int WINDOW = 32;
    localparam int ADDR_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int GATE_W = FILL_W + 3;

    localparam int SAMPLE_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SAMPLE_W-1:0]        mag_t;
    typedef logic [FILL_W-1:0]          fill_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_CALIBRATE_COUNT = 2'd0;
    localparam cfg_idx_t CFG_SPREAD_SHIFT    = 2'd1;
    localparam cfg_idx_t CFG_SHARE_QUARTERS  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [5:0] CALIBRATE_COUNT_RST = 6'd16;
    localparam logic [3:0] SPREAD_SHIFT_RST    = 4'd2;
    localparam logic [2:0] SHARE_QUARTERS_RST  = 3'd3;

    // Flags from the shared compare unit.
    typedef struct packed {
        logic lt;
        logic eq;
        logic near_hit;
    } cmp_result_t;

endpackage

@@ hw/rtl/mwgc_if.sv @@
// Handshake interfaces for the sample, result and configuration channels.
interface mwgc_in_if;
    logic             valid;
    logic             ready;
    mwgc_pkg::sample_t ratio_sample;

    modport source (output valid, output ratio_sample, input ready);
    modport sink (input valid, input ratio_sample, output ready);
endinterface

interface mwgc_out_if;
    logic             valid;
    logic             ready;
    logic             is_ready;
    mwgc_pkg::sample_t scale_out;

    modport source (output valid, output is_ready, output scale_out, input ready);
    modport sink (input valid, input is_ready, input scale_out, output ready);
endinterface

interface mwgc_cfg_if;
    logic                valid;
    logic                ready;
    mwgc_pkg::cfg_idx_t  index;
    mwgc_pkg::cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/mwgc_cmp_unit.sv @@
// Shared compare unit: ordering of two samples and the distance test against a tolerance.
module mwgc_cmp_unit (
    input  mwgc_pkg::sample_t     a,
    input  mwgc_pkg::sample_t     b,
    input  mwgc_pkg::mag_t        tol,
    output mwgc_pkg::cmp_result_t res
);
    import mwgc_pkg::*;

    logic [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0] gap;

    // One wide subtract serves ordering and distance.
    assign diff = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
    assign gap  = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;

    assign res.lt       = diff[SAMPLE_W];
    assign res.eq       = (a == b);
    assign res.near_hit = (gap <= {1'b0, tol});

endmodule

@@ hw/rtl/median_window_gain_calibrator_top.sv @@
// Top level of the median window gain calibrator: window memory, sequencer and outputs.
//
//  channel  | modport | words carried
//  ---------+---------+----------------------------------------------
//  in_ch    | sink    | ratio_sample (signed Q8.24)
//  out_ch   | source  | is_ready, scale_out (signed Q8.24)
//  cfg_ch   | sink    | index, data (calibrate_count, spread_shift, share_quarters)
//
// When no calibration is attempted, a word goes from S_IDLE straight to S_DONE. Otherwise the
// median search loads one candidate at a time and walks the window through the single read
// port of the window memory, up to n candidates for a fill of n, then walks it once more
// for the consistency count unless the median is zero.
// Reset clears the fill, the scale and the sequencer; the window needs no clearing.
// in_ch.ready is high only while the sequencer is idle; a result waiting on out_ch
// holds the sequencer in its last state. cfg_ch is always ready.
module median_window_gain_calibrator_top (
    input  logic       clk,
    input  logic       rst_n,
    mwgc_in_if.sink    in_ch,
    mwgc_out_if.source out_ch,
    mwgc_cfg_if.sink   cfg_ch
);
    import mwgc_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_OUTER = 9'b000000010,
        S_CAND  = 9'b000000100,
        S_INNER = 9'b000001000,
        S_EVAL  = 9'b000010000,
        S_MAG   = 9'b000100000,
        S_COUNT = 9'b001000000,
        S_GATE  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [5:0] calib_reg;
    logic [3:0] shift_reg;
    logic [2:0] share_reg;

    // Window bookkeeping and calibration state.
    fill_t   fill_reg, fill_next;
    addr_t   slot_reg, slot_next;
    sample_t scale_reg, scale_next;
    logic    ready_flag_reg, ready_flag_next;

    // Scan counters.
    fill_t   cand_idx_reg, cand_idx_next;
    fill_t   scan_idx_reg, scan_idx_next;
    logic    pend_reg, pend_next;
    fill_t   lt_cnt_reg, lt_cnt_next;
    fill_t   eq_cnt_reg, eq_cnt_next;
    fill_t   cons_cnt_reg, cons_cnt_next;

    // Payload registers.
    sample_t cand_reg, cand_next;
    mag_t    tol_reg, tol_next;
    sample_t rdata_reg;

    // Output register.
    logic    out_valid_reg, out_valid_next;
    logic    out_rdy_reg, out_rdy_next;
    sample_t out_scale_reg, out_scale_next;

    // Window memory.
    sample_t window_mem [WINDOW];
    addr_t   rd_addr;
    logic    wr_en;

    cmp_result_t cmp_res;
    logic        in_fire;
    logic        scan_issue;
    logic        scan_done;
    fill_t       fill_new;
    fill_t       med_pos;
    logic [FILL_W:0] rank_hi;
    logic        rank_hit;
    logic [SAMPLE_W:0] cand_ext;
    logic [SAMPLE_W:0] cand_mag;
    logic [GATE_W-1:0] gate_have;
    logic [GATE_W-1:0] gate_need;
    logic        out_load;

    assign in_fire      = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.is_ready  = out_rdy_reg;
    assign out_ch.scale_out = out_scale_reg;

    // Shared compare unit; the second operand is the candidate, which is the median once found.
    mwgc_cmp_unit u_cmp (
        .a   (rdata_reg),
        .b   (cand_reg),
        .tol (tol_reg),
        .res (cmp_res)
    );

    // Window memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            window_mem[slot_reg] <= in_ch.ratio_sample;
        end
        rdata_reg <= window_mem[rd_addr];
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_reg <= CALIBRATE_COUNT_RST;
            shift_reg <= SPREAD_SHIFT_RST;
            share_reg <= SHARE_QUARTERS_RST;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (cfg_ch.index)
                CFG_CALIBRATE_COUNT: calib_reg <= cfg_ch.data[5:0];
                CFG_SPREAD_SHIFT:    shift_reg <= cfg_ch.data[3:0];
                CFG_SHARE_QUARTERS:  share_reg <= cfg_ch.data[2:0];
                default:             ;
            endcase
        end
    end

    // Helpers for the sequencer.
    assign fill_new   = (fill_reg < FILL_W'(WINDOW)) ? fill_reg + 1'b1 : fill_reg;
    assign scan_issue = (scan_idx_reg < fill_reg);
    assign scan_done  = !scan_issue && !pend_reg;
    assign med_pos    = fill_reg >> 1;
    assign rank_hi    = {1'b0, lt_cnt_reg} + {1'b0, eq_cnt_reg};
    assign rank_hit   = (med_pos >= lt_cnt_reg) && ({1'b0, med_pos} < rank_hi);
    assign cand_ext   = {cand_reg[SAMPLE_W-1], cand_reg};
    assign cand_mag   = cand_ext[SAMPLE_W] ? (~cand_ext + 1'b1) : cand_ext;
    assign gate_have  = GATE_W'({cons_cnt_reg, 2'b00});
    assign gate_need  = GATE_W'(share_reg) * GATE_W'(fill_reg);
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        slot_next       = slot_reg;
        scale_next      = scale_reg;
        ready_flag_next = ready_flag_reg;
        cand_idx_next   = cand_idx_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = 1'b0;
        lt_cnt_next     = lt_cnt_reg;
        eq_cnt_next     = eq_cnt_reg;
        cons_cnt_next   = cons_cnt_reg;
        cand_next       = cand_reg;
        tol_next        = tol_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    wr_en           = 1'b1;
                    slot_next       = (slot_reg == addr_t'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                    fill_next       = fill_new;
                    ready_flag_next = 1'b0;
                    cand_idx_next   = '0;
                    if (fill_new >= FILL_W'(calib_reg))
                    begin
                        state_next = S_OUTER;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_OUTER:
            begin
                rd_addr    = cand_idx_reg[ADDR_W-1:0];
                state_next = S_CAND;
            end
            S_CAND:
            begin
                cand_next     = rdata_reg;
                scan_idx_next = '0;
                lt_cnt_next   = '0;
                eq_cnt_next   = '0;
                state_next    = S_INNER;
            end
            S_INNER:
            begin
                // Count window entries below and equal to the candidate.
                rd_addr = scan_idx_reg[ADDR_W-1:0];
                if (scan_issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                end
                if (pend_reg)
                begin
                    lt_cnt_next = lt_cnt_reg + FILL_W'(cmp_res.lt);
                    eq_cnt_next = eq_cnt_reg + FILL_W'(cmp_res.eq);
                end
                if (scan_done)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (rank_hit)
                begin
                    state_next = S_MAG;
                end
                else
                begin
                    cand_idx_next = cand_idx_reg + 1'b1;
                    state_next    = S_OUTER;
                end
            end
            S_MAG:
            begin
                tol_next      = cand_mag[SAMPLE_W-1:0] >> shift_reg;
                scan_idx_next = '0;
                cons_cnt_next = '0;
                if (cand_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                // Count window entries within the tolerance of the median.
                rd_addr = scan_idx_reg[ADDR_W-1:0];
                if (scan_issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                end
                if (pend_reg)
                begin
                    cons_cnt_next = cons_cnt_reg + FILL_W'(cmp_res.near_hit);
                end
                if (scan_done)
                begin
                    state_next = S_GATE;
                end
            end
            S_GATE:
            begin
                if (gate_have >= gate_need)
                begin
                    scale_next      = cand_reg;
                    ready_flag_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: loaded when the sequencer finishes, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_rdy_next   = out_rdy_reg;
        out_scale_next = out_scale_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_rdy_next   = ready_flag_reg;
            out_scale_next = scale_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            slot_reg       <= '0;
            scale_reg      <= '0;
            ready_flag_reg <= 1'b0;
            cand_idx_reg   <= '0;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            lt_cnt_reg     <= '0;
            eq_cnt_reg     <= '0;
            cons_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            slot_reg       <= slot_next;
            scale_reg      <= scale_next;
            ready_flag_reg <= ready_flag_next;
            cand_idx_reg   <= cand_idx_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            lt_cnt_reg     <= lt_cnt_next;
            eq_cnt_reg     <= eq_cnt_next;
            cons_cnt_reg   <= cons_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        tol_reg       <= tol_next;
        out_rdy_reg   <= out_rdy_next;
        out_scale_reg <= out_scale_next;
    end

endmodule
